// File: rtl/core/ghi_pkg.sv
`default_nettype none

package ghi_pkg;

  // Item field widths
  localparam int RAW_W   = 16;
  localparam int TS_W    = 32;
  localparam int DZ_W    = 15;
  localparam int DT_W    = 20;
  localparam int HDG_W   = 9;

  // Datapath widths
  localparam int RATE_W  = RAW_W + 1;            // raw minus bias
  localparam int PROD_W  = RATE_W + DT_W + 1;    // signed rate * unsigned dt
  localparam int RED_W   = PROD_W + 1;           // room for +2 turns
  localparam int ACC_W   = 36;                   // [0, one turn)

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DT_W;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 1'b1;

  localparam logic [DZ_W-1:0] DEADZONE_RST     = '0;
  localparam logic [DT_W-1:0] MAX_INTERVAL_RST = DT_W'(100000);

  // Angle units: LSB * us. One degree = 131 LSB/(deg/s) * 1e6 us.
  localparam logic [ACC_W-1:0] DEG_UNIT  = ACC_W'(64'd131000000);
  localparam logic [ACC_W-1:0] FULL_TURN = ACC_W'(64'd47160000000);

  // Readout reciprocal: top 16 bits of the angle times 2^44 / DEG_UNIT
  localparam int DEG_TOP_LSB     = 20;
  localparam int DEG_RECIP_SHIFT = 24;
  localparam int DEG_RECIP_W     = 18;
  localparam logic [DEG_RECIP_W-1:0] DEG_RECIP =
    DEG_RECIP_W'((64'd1 << (DEG_TOP_LSB + DEG_RECIP_SHIFT)) / 64'd131000000);

  localparam int CALIB_SAMPLES_DEF = 250;

  typedef enum logic [1:0] {
    CLS_RESTART,
    CLS_CAL,
    CLS_RATE
  } item_cls_t;

endpackage

`default_nettype wire

// File: rtl/core/gyro_heading_integrator_unit.sv
`default_nettype none

// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+------------------------------------------
// in_      | input     | in_valid / in_ready   | in_operation, in_raw_rate, in_timestamp_us
// out_     | output    | out_valid / out_ready | out_heading_deg, out_calibrating
// cfg_     | input     | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// Throughput: one item per cycle unless out_ready stalls the output. Feedback loops:
// calibration sum (stage 1), angle accumulate (stage 7).
// Sync active-low reset clears valid bits, calibration state, bias, accumulator,
// previous timestamp and config registers; no clearing pass.
// A stage moves when the next one is empty or moving, so bubbles collapse and
// inputs are taken while a result waits at the output.

module gyro_heading_integrator_unit
  import ghi_pkg::*;
#(
  parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF   // 1 .. 1024
) (
  input  wire                          clk,
  input  wire                          rst_n,

  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_operation,
  input  wire  signed [RAW_W-1:0]      in_raw_rate,
  input  wire         [TS_W-1:0]       in_timestamp_us,

  output logic                         out_valid,
  input  wire                          out_ready,
  output logic        [HDG_W-1:0]      out_heading_deg,
  output logic                         out_calibrating,

  input  wire                          cfg_we,
  input  wire         [CFG_IDX_W-1:0]  cfg_index,
  input  wire         [CFG_DATA_W-1:0] cfg_wdata
);

  // Calibration sizing. |sum| <= N * 2^15 fits SUM_W signed bits.
  localparam int CLOG_N = $clog2(CALIB_SAMPLES);
  localparam int CNT_W  = $clog2(CALIB_SAMPLES + 1);
  localparam int SUM_W  = RAW_W + CLOG_N;
  localparam logic [CNT_W-1:0] CALIB_TGT = CNT_W'(CALIB_SAMPLES);

  // Exact divide by N: floor(x * ceil(2^K / N) / 2^K) for x < 2^SUM_W
  localparam int BIAS_K = SUM_W + CLOG_N;
  localparam int MUL_W  = SUM_W + 2;
  localparam int BP_W   = SUM_W + MUL_W;
  localparam longint unsigned BIAS_MUL_FULL =
    ((64'd1 << BIAS_K) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES);
  localparam logic [MUL_W-1:0] BIAS_MUL = MUL_W'(BIAS_MUL_FULL);

  localparam int NST = 11;   // stage 11 is the output register
  localparam logic signed [RED_W-1:0] FT_RED  = RED_W'(FULL_TURN);
  localparam logic signed [RED_W-1:0] FT2_RED = RED_W'(FULL_TURN) <<< 1;

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic [NST:1]   v_r;
  logic [NST+1:1] rdy;

  always_comb begin
    rdy[NST+1] = out_ready;
    for (int k = NST; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (rdy[NST:1] & {v_r[NST-1:1], in_valid}) | (~rdy[NST:1] & v_r);
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = v_r[NST];

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DZ_W-1:0] deadzone_r;
  logic [DT_W-1:0] max_interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r     <= DEADZONE_RST;
      max_interval_r <= MAX_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEADZONE:     deadzone_r     <= cfg_wdata[DZ_W-1:0];
        REG_MAX_INTERVAL: max_interval_r <= cfg_wdata[DT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register. Every item updates the previous timestamp, so
  // the previous one rides along with the item.
  // ---------------------------------------------------------------------------
  logic                    s1_restart_r;
  logic signed [RAW_W-1:0] s1_raw_r;
  logic [TS_W-1:0]         s1_ts_r;
  logic [TS_W-1:0]         s1_pts_r;
  logic [TS_W-1:0]         prev_ts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ts_r <= '0;
    end else if (in_valid && in_ready) begin
      prev_ts_r <= in_timestamp_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_restart_r <= in_operation;
      s1_raw_r     <= in_raw_rate;
      s1_ts_r      <= in_timestamp_us;
      s1_pts_r     <= prev_ts_r;
    end
  end

  // Classification, calibration accumulate, elapsed time
  logic signed [SUM_W-1:0] cal_sum_r, cal_sum_add, cal_sum_nxt;
  logic [CNT_W-1:0]        cal_cnt_r, cal_cnt_inc, cal_cnt_nxt;
  logic                    s1_is_cal, s1_done, s1_calib, s1_neg;
  logic [SUM_W-1:0]        s1_mag;
  item_cls_t               s1_cls;
  logic [TS_W-1:0]         s1_dt_full;
  logic [DT_W-1:0]         s1_dt;

  always_comb begin
    s1_is_cal   = !s1_restart_r && (cal_cnt_r < CALIB_TGT);
    cal_cnt_inc = cal_cnt_r + 1'b1;
    cal_sum_add = cal_sum_r + SUM_W'(s1_raw_r);
    s1_done     = s1_is_cal && (cal_cnt_inc == CALIB_TGT);

    if (s1_restart_r) begin
      s1_cls      = CLS_RESTART;
      cal_cnt_nxt = '0;
      cal_sum_nxt = '0;
      s1_calib    = 1'b1;
    end else if (s1_is_cal) begin
      s1_cls      = CLS_CAL;
      cal_cnt_nxt = cal_cnt_inc;
      cal_sum_nxt = cal_sum_add;
      s1_calib    = !s1_done;
    end else begin
      s1_cls      = CLS_RATE;
      cal_cnt_nxt = cal_cnt_r;
      cal_sum_nxt = cal_sum_r;
      s1_calib    = 1'b0;
    end

    s1_neg = cal_sum_add[SUM_W-1];
    s1_mag = s1_neg ? SUM_W'(-cal_sum_add) : SUM_W'(cal_sum_add);

    // modulo-2^32 difference, saturated
    s1_dt_full = s1_ts_r - s1_pts_r;
    s1_dt      = (s1_dt_full > TS_W'(max_interval_r)) ? max_interval_r
                                                       : s1_dt_full[DT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_cnt_r <= '0;
      cal_sum_r <= '0;
    end else if (v_r[1] && rdy[2]) begin
      cal_cnt_r <= cal_cnt_nxt;
      cal_sum_r <= cal_sum_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: bias reciprocal multiply
  // ---------------------------------------------------------------------------
  item_cls_t               s2_cls_r;
  logic signed [RAW_W-1:0] s2_raw_r;
  logic [DT_W-1:0]         s2_dt_r;
  logic                    s2_calib_r, s2_done_r, s2_neg_r;
  logic [SUM_W-1:0]        s2_mag_r;
  logic [BP_W-1:0]         s2_bprod;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_cls_r   <= s1_cls;
      s2_raw_r   <= s1_raw_r;
      s2_dt_r    <= s1_dt;
      s2_calib_r <= s1_calib;
      s2_done_r  <= s1_done;
      s2_neg_r   <= s1_neg;
      s2_mag_r   <= s1_mag;
    end
  end

  assign s2_bprod = BP_W'(s2_mag_r) * BP_W'(BIAS_MUL);

  // ---------------------------------------------------------------------------
  // Stage 3: bias quotient, sign restored (truncation toward zero)
  // ---------------------------------------------------------------------------
  item_cls_t               s3_cls_r;
  logic signed [RAW_W-1:0] s3_raw_r;
  logic [DT_W-1:0]         s3_dt_r;
  logic                    s3_calib_r, s3_done_r, s3_neg_r;
  logic [BP_W-1:0]         s3_bprod_r;
  logic [RAW_W-1:0]        s3_bias_q;
  logic signed [RAW_W-1:0] bias_nxt, bias_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_cls_r   <= s2_cls_r;
      s3_raw_r   <= s2_raw_r;
      s3_dt_r    <= s2_dt_r;
      s3_calib_r <= s2_calib_r;
      s3_done_r  <= s2_done_r;
      s3_neg_r   <= s2_neg_r;
      s3_bprod_r <= s2_bprod;
    end
  end

  assign s3_bias_q = s3_bprod_r[BIAS_K +: RAW_W];
  assign bias_nxt  = s3_neg_r ? RAW_W'(-s3_bias_q) : s3_bias_q;

  // Written as the finishing calibration item moves on; later items read
  // the bias in stage 4, so they always see it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else if (v_r[3] && rdy[4] && s3_done_r) begin
      bias_r <= bias_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: bias subtract and deadzone
  // ---------------------------------------------------------------------------
  item_cls_t               s4_cls_r;
  logic signed [RAW_W-1:0] s4_raw_r;
  logic [DT_W-1:0]         s4_dt_r;
  logic                    s4_calib_r;
  logic signed [RATE_W-1:0] s4_rate, s4_rate_dz;
  logic [RATE_W-1:0]       s4_mag;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_cls_r   <= s3_cls_r;
      s4_raw_r   <= s3_raw_r;
      s4_dt_r    <= s3_dt_r;
      s4_calib_r <= s3_calib_r;
    end
  end

  always_comb begin
    s4_rate    = RATE_W'(s4_raw_r) - RATE_W'(bias_r);
    s4_mag     = s4_rate[RATE_W-1] ? RATE_W'(-s4_rate) : RATE_W'(s4_rate);
    s4_rate_dz = (s4_mag < RATE_W'(deadzone_r)) ? '0 : s4_rate;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: rate * elapsed time
  // ---------------------------------------------------------------------------
  item_cls_t                s5_cls_r;
  logic signed [RATE_W-1:0] s5_rate_r;
  logic [DT_W-1:0]          s5_dt_r;
  logic                     s5_calib_r;
  logic signed [DT_W:0]     s5_dt_s;
  logic signed [PROD_W-1:0] s5_prod;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_cls_r   <= s4_cls_r;
      s5_rate_r  <= s4_rate_dz;
      s5_dt_r    <= s4_dt_r;
      s5_calib_r <= s4_calib_r;
    end
  end

  assign s5_dt_s = {1'b0, s5_dt_r};
  assign s5_prod = s5_rate_r * s5_dt_s;

  // ---------------------------------------------------------------------------
  // Stage 6: reduce the step into [0, one turn). |step| < 2 turns, so one of
  // four candidates is in range.
  // ---------------------------------------------------------------------------
  item_cls_t                s6_cls_r;
  logic signed [PROD_W-1:0] s6_prod_r;
  logic                     s6_calib_r;
  logic signed [RED_W-1:0]  s6_c0, s6_cm1, s6_cp1, s6_cp2, s6_sel;
  logic [ACC_W-1:0]         s6_step;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_cls_r   <= s5_cls_r;
      s6_prod_r  <= s5_prod;
      s6_calib_r <= s5_calib_r;
    end
  end

  always_comb begin
    s6_c0  = RED_W'(s6_prod_r);
    s6_cm1 = s6_c0 - FT_RED;
    s6_cp1 = s6_c0 + FT_RED;
    s6_cp2 = s6_c0 + FT2_RED;
    if (!s6_cm1[RED_W-1]) begin
      s6_sel = s6_cm1;
    end else if (!s6_c0[RED_W-1]) begin
      s6_sel = s6_c0;
    end else if (!s6_cp1[RED_W-1]) begin
      s6_sel = s6_cp1;
    end else begin
      s6_sel = s6_cp2;
    end
    s6_step = s6_sel[ACC_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 7: accumulator, wraps at one turn
  // ---------------------------------------------------------------------------
  item_cls_t        s7_cls_r;
  logic [ACC_W-1:0] s7_step_r;
  logic             s7_calib_r;
  logic [ACC_W:0]   s7_sum;
  logic [ACC_W-1:0] acc_r, acc_nxt;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_cls_r   <= s6_cls_r;
      s7_step_r  <= s6_step;
      s7_calib_r <= s6_calib_r;
    end
  end

  always_comb begin
    s7_sum = {1'b0, acc_r} + {1'b0, s7_step_r};
    case (s7_cls_r)
      CLS_RESTART: acc_nxt = '0;
      CLS_CAL:     acc_nxt = acc_r;
      CLS_RATE:    acc_nxt = (s7_sum >= {1'b0, FULL_TURN})
                             ? ACC_W'(s7_sum - {1'b0, FULL_TURN})
                             : s7_sum[ACC_W-1:0];
      default:     acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (v_r[7] && rdy[8]) begin
      acc_r <= acc_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 8-10: degrees = floor(acc / DEG_UNIT). Estimate from top bits is
  // exact or one low; one compare fixes it.
  // ---------------------------------------------------------------------------
  logic [ACC_W-1:0]                     s8_acc_r;
  logic                                 s8_calib_r;
  logic [ACC_W-DEG_TOP_LSB+DEG_RECIP_W-1:0] s8_qprod;
  logic [HDG_W-1:0]                     s8_q0;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_acc_r   <= acc_nxt;
      s8_calib_r <= s7_calib_r;
    end
  end

  assign s8_qprod = s8_acc_r[ACC_W-1:DEG_TOP_LSB] * DEG_RECIP;
  assign s8_q0    = s8_qprod[DEG_RECIP_SHIFT +: HDG_W];

  logic [ACC_W-1:0] s9_acc_r, s9_qd;
  logic [HDG_W-1:0] s9_q0_r;
  logic             s9_calib_r;

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      s9_acc_r   <= s8_acc_r;
      s9_q0_r    <= s8_q0;
      s9_calib_r <= s8_calib_r;
    end
  end

  assign s9_qd = ACC_W'(s9_q0_r) * DEG_UNIT;

  logic [ACC_W-1:0] s10_acc_r, s10_qd_r, s10_rem;
  logic [HDG_W-1:0] s10_q0_r, s10_hdg;
  logic             s10_calib_r;

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      s10_acc_r   <= s9_acc_r;
      s10_q0_r    <= s9_q0_r;
      s10_qd_r    <= s9_qd;
      s10_calib_r <= s9_calib_r;
    end
  end

  assign s10_rem = s10_acc_r - s10_qd_r;
  assign s10_hdg = (s10_rem >= DEG_UNIT) ? s10_q0_r + 1'b1 : s10_q0_r;

  // ---------------------------------------------------------------------------
  // Stage 11: output register
  // ---------------------------------------------------------------------------
  logic [HDG_W-1:0] out_hdg_r;
  logic             out_calib_r;

  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      out_hdg_r   <= s10_hdg;
      out_calib_r <= s10_calib_r;
    end
  end

  assign out_heading_deg = out_hdg_r;
  assign out_calibrating = out_calib_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_acc_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r < FULL_TURN)
    else $error("angle accumulator left [0, one turn)");

  a_hdg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heading_deg < HDG_W'(360))
    else $error("heading readout out of range");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cal_cnt_r <= CALIB_TGT)
    else $error("calibration count passed its target");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[1] && rdy[2] && s1_restart_r) |=> (cal_cnt_r == '0 && cal_sum_r == '0))
    else $error("restart did not clear calibration state");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r && !out_ready))
    else $error("input stalled with a bubble in the pipeline");

endmodule

`default_nettype wire

// File: dv/gyro_heading_integrator_unit_test.sv
`timescale 1ns / 100ps

module gyro_heading_integrator_unit_test;
  import ghi_pkg::*;

  // Operation codes of an input item
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Calibration length of the default build
  localparam int CAL_N = CALIB_SAMPLES_DEF;

  // Angle units: LSB * us. One degree, one full turn.
  localparam longint DEG_UNITS  = 64'sd131000000;
  localparam longint TURN_UNITS = 64'sd47160000000;

  localparam int RATE_ITEMS  = 30;       // post-calibration items per random phase
  localparam int QUIET_WAIT  = 16;       // pipeline is 11 deep, leave a margin
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [HDG_W-1:0] heading_deg;
    logic             calibrating;
  } heading_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_operation = OP_SAMPLE;
  logic signed [RAW_W-1:0] in_raw_rate = '0;
  logic [TS_W-1:0]       in_timestamp_us = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [HDG_W-1:0]      out_heading_deg;
  logic                  out_calibrating;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DEADZONE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  gyro_heading_integrator_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_raw_rate     (in_raw_rate),
    .in_timestamp_us (in_timestamp_us),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_heading_deg (out_heading_deg),
    .out_calibrating (out_calibrating),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Heading model state, kept in step with every accepted item
  longint          hdg_acc;
  int              bias_lsb;
  int              cal_sum;
  int              cal_count;
  logic [TS_W-1:0] last_ts;
  logic [DZ_W-1:0] dz_lsb;
  logic [DT_W-1:0] max_dt_us;

  heading_result_t heading_q[$];   // expected results, oldest first
  int              fail_count = 0;
  int              cycle_count = 0;

  // Idle percentages of the sender and the receiver
  int              send_gap_pct = 0;
  int              recv_stall_pct = 0;

  // Stimulus-side copies used to aim the random items
  logic [TS_W-1:0] cur_ts = '0;

  function automatic heading_result_t integrate_heading(logic op, logic signed [RAW_W-1:0] raw,
                                                        logic [TS_W-1:0] ts);
    heading_result_t res;
    int              r;
    int              rate;
    int              mag;
    logic [TS_W-1:0] dt;
    longint          sum;
    r = raw;
    if (op == OP_RESTART) begin
      // heading and calibration start over, bias survives until the next one ends
      hdg_acc   = 0;
      cal_sum   = 0;
      cal_count = 0;
      last_ts   = ts;
    end else if (cal_count < CAL_N) begin
      cal_sum   = cal_sum + r;
      cal_count = cal_count + 1;
      last_ts   = ts;
      if (cal_count >= CAL_N)
        bias_lsb = cal_sum / CAL_N;     // truncates toward zero
    end else begin
      rate    = r - bias_lsb;
      mag     = (rate < 0) ? -rate : rate;
      dt      = ts - last_ts;           // modulo 2^32
      last_ts = ts;
      if (mag < int'(dz_lsb))
        rate = 0;
      if (dt > TS_W'(max_dt_us))
        dt = TS_W'(max_dt_us);
      sum = hdg_acc + longint'(rate) * longint'(dt);
      sum = sum % TURN_UNITS;
      if (sum < 0)
        sum = sum + TURN_UNITS;
      hdg_acc = sum;
    end
    res.heading_deg = HDG_W'(hdg_acc / DEG_UNITS);
    res.calibrating = (cal_count < CAL_N);
    return res;
  endfunction

  // Offer one item at a falling edge, hold it until accepted, then predict it
  task automatic send_item(logic op, logic signed [RAW_W-1:0] raw, logic [TS_W-1:0] ts);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_raw_rate     <= raw;
    in_timestamp_us <= ts;
    do @(posedge clk); while (!in_ready);
    heading_q.push_back(integrate_heading(op, raw, ts));
  endtask

  // Drop valid, let every expected result out, then let the pipe settle
  task automatic wait_for_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (heading_q.size() != 0)
      @(posedge clk);
    repeat (QUIET_WAIT) @(negedge clk);
  endtask

  // Both registers, back to back; only called while the block is quiet
  task automatic set_config(logic [CFG_DATA_W-1:0] dz_word, logic [CFG_DATA_W-1:0] iv_word);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEADZONE;
    cfg_wdata <= dz_word;
    dz_lsb     = dz_word[DZ_W-1:0];
    @(negedge clk);
    cfg_index <= REG_MAX_INTERVAL;
    cfg_wdata <= iv_word;
    max_dt_us  = iv_word;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Raw rate for an integrating item: full range, near the bias and the
  // deadzone edge, the extremes, or a modest turn
  function automatic logic signed [RAW_W-1:0] pick_rate_raw();
    int v;
    int sel;
    int dz;
    sel = $urandom_range(9);
    dz  = dz_lsb;
    case (sel)
      0, 1, 2: v = $signed(RAW_W'($urandom));
      3, 4, 5: v = bias_lsb + $urandom_range(2 * dz + 6) - dz - 3;
      6:       v = $urandom_range(1) ? 32767 : -32768;
      default: v = int'($urandom_range(1000)) - 500;
    endcase
    if (v > 32767)
      v = 32767;
    if (v < -32768)
      v = -32768;
    return RAW_W'(v);
  endfunction

  // Next timestamp: mostly a step around the clamp, sometimes none,
  // a jump backward (huge modulo distance) or anywhere at all
  function automatic logic [TS_W-1:0] next_rate_ts();
    int sel;
    sel = $urandom_range(15);
    case (sel)
      0:       cur_ts = $urandom;
      1:       cur_ts = cur_ts;
      2:       cur_ts = cur_ts - $urandom_range(1, 5000);
      default: cur_ts = cur_ts + $urandom_range(int'(max_dt_us) + int'(max_dt_us) / 4 + 1);
    endcase
    return cur_ts;
  endfunction

  // Restart items with the extremes of every field
  task automatic test_restart_fields();
    send_item(OP_RESTART, 16'sh7FFF, 32'hFFFF_FFFF);
    send_item(OP_RESTART, 16'sh8000, 32'h0000_0000);
    send_item(OP_RESTART, 16'sh5555, 32'hAAAA_AAAA);
  endtask

  // Calibration samples at the extremes, a restart in the middle of a
  // calibration, and timestamps that wrap
  task automatic test_calibration_edges();
    send_item(OP_SAMPLE, 16'sh8000, 32'hFFFF_FFF0);
    send_item(OP_SAMPLE, 16'sh7FFF, 32'h0000_0010);
    send_item(OP_SAMPLE, 16'sh0000, 32'h5555_5555);
    send_item(OP_SAMPLE, -16'sd1, 32'hFFFF_FFFF);
    send_item(OP_SAMPLE, 16'sd1, 32'h0000_0000);
    send_item(OP_RESTART, 16'sh1234, 32'h8000_0000);
    send_item(OP_SAMPLE, 16'sh7FFF, 32'h7FFF_FFFF);
    send_item(OP_SAMPLE, 16'sh8000, 32'h8000_0001);
    send_item(OP_RESTART, 16'sh0000, 32'h0000_0000);
  endtask

  // Block is calibrated here: a zero clamp adds nothing, a clamp of one
  // adds at most a single rate step whatever the gap
  task automatic test_interval_extremes();
    wait_for_quiet();
    set_config('0, '0);
    repeat (6) send_item(OP_SAMPLE, pick_rate_raw(), next_rate_ts());
    wait_for_quiet();
    set_config(CFG_DATA_W'(1), CFG_DATA_W'(1));
    repeat (6) send_item(OP_SAMPLE, pick_rate_raw(), next_rate_ts());
  endtask

  // One random phase: restart, a full calibration with the odd aborted one,
  // then a run of integrating items
  task automatic test_random_phase(int phase);
    int n;
    int aborts;
    int center;
    logic signed [RAW_W-1:0] raw;
    wait_for_quiet();
    case (phase)
      0: begin
        // reset values of both registers stay in force
        send_gap_pct   = 18;
        recv_stall_pct = 45;
      end
      1: begin
        send_gap_pct   = 45;
        recv_stall_pct = 18;
        set_config({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}});
      end
      default: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        set_config(CFG_DATA_W'($urandom_range(300)), CFG_DATA_W'($urandom_range(1, 1048575)));
      end
    endcase
    center = int'($urandom_range(6000)) - 3000;
    cur_ts = $urandom;
    send_item(OP_RESTART, RAW_W'($urandom), cur_ts);
    n      = 0;
    aborts = 0;
    while (n < CAL_N) begin
      // biased samples: around a random offset, or pinned near either rail
      case (phase)
        0:       raw = RAW_W'(center + int'($urandom_range(80)) - 40);
        1:       raw = RAW_W'(32767 - int'($urandom_range(3)));
        default: raw = RAW_W'(-32768 + int'($urandom_range(3)));
      endcase
      cur_ts = cur_ts + $urandom_range(20000);
      // at most one abort, early on, to keep the item count in bounds
      if (aborts < 1 && n < 40 && $urandom_range(39) == 0) begin
        send_item(OP_RESTART, raw, cur_ts);
        aborts++;
        n = 0;
      end else begin
        send_item(OP_SAMPLE, raw, cur_ts);
        n++;
      end
    end
    repeat (RATE_ITEMS) send_item(OP_SAMPLE, pick_rate_raw(), next_rate_ts());
  endtask

  // Receiver stalls, redrawn every falling edge
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    heading_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (heading_q.size() == 0) begin
        $display("%0t: unexpected result heading %0d calibrating %0b", $time,
                 out_heading_deg, out_calibrating);
        fail_count++;
      end else begin
        want = heading_q.pop_front();
        if (out_heading_deg !== want.heading_deg) begin
          $display("%0t: heading_deg expected %0d actual %0d", $time,
                   want.heading_deg, out_heading_deg);
          fail_count++;
        end
        if (out_calibrating !== want.calibrating) begin
          $display("%0t: calibrating expected %0b actual %0b", $time,
                   want.calibrating, out_calibrating);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    // model starts at the reset state
    hdg_acc   = 0;
    bias_lsb  = 0;
    cal_sum   = 0;
    cal_count = 0;
    last_ts   = '0;
    dz_lsb    = DEADZONE_RST;
    max_dt_us = MAX_INTERVAL_RST;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    send_gap_pct   = 18;
    recv_stall_pct = 45;
    test_calibration_edges();
    test_restart_fields();
    test_random_phase(0);
    test_interval_extremes();
    test_random_phase(1);
    test_random_phase(2);
    wait_for_quiet();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ghi_pkg.sv
rtl/core/gyro_heading_integrator_unit.sv
dv/gyro_heading_integrator_unit_test.sv
